@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, held off during reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/spsp_pkg.sv @@
// ----------------------------------------------------------------------------
// spsp_pkg
// Shared types and constants of the shortest path core.
// ----------------------------------------------------------------------------
package spsp_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int MAX_EDGES  = 4096;
    localparam int HEAP_DEPTH = 4096;

    localparam int NODE_W = 10;
    localparam int EIDX_W = 12;
    localparam int HIDX_W = 12;
    localparam int CNT_W  = 13;
    localparam int WGT_W  = 32;
    localparam int DIST_W = 64;
    localparam int LEN_W  = 48;
    localparam int NCFG_W = 11;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_EDGE  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [DIST_W-1:0] UNREACHABLE = '1;
    localparam logic [LEN_W-1:0]  LEN_MAX     = '1;

    typedef struct packed {
        logic [1:0]        action;
        logic [NODE_W-1:0] edge_from;
        logic [NODE_W-1:0] edge_to;
        logic [WGT_W-1:0]  edge_weight;
        logic [NODE_W-1:0] source_node;
        logic [NODE_W-1:0] target_node;
    } spsp_in_t;

    typedef struct packed {
        logic [LEN_W-1:0] path_length;
        logic             found;
        logic             overflow;
    } spsp_out_t;

    // edge list link: valid flag plus index
    typedef struct packed {
        logic              vld;
        logic [EIDX_W-1:0] idx;
    } elink_t;

    typedef struct packed {
        logic [NODE_W-1:0] to;
        logic [WGT_W-1:0]  weight;
        elink_t            next;
    } edge_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [DIST_W-1:0] cost;
    } hent_t;

endpackage

@@ src/single_pair_shortest_path_core.sv @@
// Shortest path core: an edge load reads the list head and then writes the
// edge and the new list head (a dropped edge only sets the lost-edge flag),
// a clear sweeps the 1024-entry list-head memory, and a query first sweeps
// the distance memory and then pops heap entries, sifting the heap down, and
// scans each popped node's edges, pushing each improved node and raising it
// up the heap. After reset the list-head memory is cleared before the first
// request is taken; configuration writes are accepted throughout.
// ----------------------------------------------------------------------------
// single_pair_shortest_path_core
// Dijkstra single-pair shortest path over a loaded directed graph.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module single_pair_shortest_path_core import spsp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [NCFG_W-1:0] cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  spsp_in_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output spsp_out_t         m_data
);
    logic [NCFG_W-1:0] node_count_reg;
    logic              res_miss;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NCFG_W'(MAX_NODES);
        end else if (cfg_we) begin
            node_count_reg <= cfg_wdata;
        end
    end

    spsp_engine u_engine (
        .aclk(aclk), .aresetn(aresetn), .node_count(node_count_reg),
        .req_valid(s_valid), .req_ready(s_ready), .req(s_data),
        .res_valid(m_valid), .res_ready(m_ready), .res(m_data)
    );

    assign res_miss = m_valid && !m_data.found;

    `ASSERT_IMPL(a_no_take_while_busy, aclk, aresetn, m_valid, !s_ready, "request while busy")
    `ASSERT_IMPL(a_found_len, aclk, aresetn, res_miss, ~|m_data.path_length, "stray length")
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "dropped")
endmodule

@@ src/spsp_ram.sv @@
// ----------------------------------------------------------------------------
// spsp_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module spsp_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ src/spsp_engine.sv @@
// ----------------------------------------------------------------------------
// spsp_engine
// Sequencer: graph load, per-node clearing sweeps, heap pop/push and
// edge relaxation, all through single-port memories.
// ----------------------------------------------------------------------------
module spsp_engine import spsp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [NCFG_W-1:0] node_count,
    input  logic              req_valid,
    output logic              req_ready,
    input  spsp_in_t          req,
    output logic              res_valid,
    input  logic              res_ready,
    output spsp_out_t         res
);
    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_EHEAD_RD, S_EHEAD_WR, S_DCLR,
        S_POP_RD0, S_POP_RDL, S_POP_CHK, S_SIFT_RC, S_SIFT_RC2, S_SIFT_CMP,
        S_SIFT_WR, S_HEAD_RD, S_HEAD_W, S_EDGE_RD, S_EDGE_W, S_DIST_W,
        S_PUSH_RP, S_PUSH_CMP, S_DONE
    } state_t;

    state_t state_reg;

    // memory ports
    logic              e_we, h_we, d_we, hd_we;
    logic [EIDX_W-1:0] e_addr;
    edge_t             e_wd, e_rd;
    logic [HIDX_W-1:0] h_addr;
    hent_t             h_wd, h_rd;
    logic [NODE_W-1:0] d_addr, hd_addr;
    logic [DIST_W-1:0] d_wd, d_rd;
    elink_t            hd_wd, hd_rd;

    spsp_ram #(.DEPTH(MAX_EDGES), .WIDTH($bits(edge_t))) u_edge (
        .aclk(aclk), .we(e_we), .addr(e_addr), .wdata(e_wd), .rdata(e_rd));
    spsp_ram #(.DEPTH(HEAP_DEPTH), .WIDTH($bits(hent_t))) u_heap (
        .aclk(aclk), .we(h_we), .addr(h_addr), .wdata(h_wd), .rdata(h_rd));
    spsp_ram #(.DEPTH(MAX_NODES), .WIDTH(DIST_W)) u_dist (
        .aclk(aclk), .we(d_we), .addr(d_addr), .wdata(d_wd), .rdata(d_rd));
    spsp_ram #(.DEPTH(MAX_NODES), .WIDTH($bits(elink_t))) u_ehead (
        .aclk(aclk), .we(hd_we), .addr(hd_addr), .wdata(hd_wd), .rdata(hd_rd));

    logic [CNT_W-1:0]  edge_cnt_reg;
    logic              edge_lost_reg;
    logic [CNT_W-1:0]  hsize_reg;
    logic [NODE_W:0]   sweep_reg;
    spsp_in_t          cmd_reg;
    logic [NCFG_W-1:0] n_reg;
    hent_t             cur_reg, last_reg, cchild_reg;
    logic [CNT_W-1:0]  pos_reg, child_reg;
    elink_t            elink_reg;
    edge_t             edge_reg;
    logic [DIST_W-1:0] nd_reg;

    logic [NCFG_W-1:0] n_eff;
    assign n_eff = (node_count > NCFG_W'(MAX_NODES)) ? NCFG_W'(MAX_NODES) : node_count;

    assign req_ready = (state_reg == S_IDLE) && !res_valid;

    logic [CNT_W-1:0]  parent;
    logic [CNT_W-1:0]  lchild;
    logic [DIST_W-1:0] nd_sum;
    logic              take_right;
    hent_t             sift_pick;
    logic              sift_stop;
    logic              relax_ok;
    assign parent = (pos_reg - 1'b1) >> 1;
    assign lchild = {pos_reg[CNT_W-2:0], 1'b1};
    assign nd_sum = cur_reg.cost + DIST_W'(edge_reg.weight);
    // h_rd is right child if in range
    assign take_right = ((child_reg + 1'b1) < hsize_reg) && (h_rd.cost < cchild_reg.cost);
    assign sift_pick  = take_right ? h_rd : cchild_reg;
    assign sift_stop  = sift_pick.cost >= last_reg.cost;
    assign relax_ok   = (NCFG_W'(edge_reg.to) < n_reg) && (nd_sum < d_rd);

    always_comb begin
        e_we = 1'b0; e_addr = elink_reg.idx; e_wd = '0;
        h_we = 1'b0; h_addr = '0; h_wd = '0;
        d_we = 1'b0; d_addr = '0; d_wd = UNREACHABLE;
        hd_we = 1'b0; hd_addr = cmd_reg.edge_from; hd_wd = '0;
        case (state_reg)
            S_INIT: begin
                hd_we = 1'b1; hd_addr = sweep_reg[NODE_W-1:0];
            end
            S_EHEAD_WR: begin
                e_we = 1'b1; e_addr = edge_cnt_reg[EIDX_W-1:0];
                e_wd = '{to: cmd_reg.edge_to, weight: cmd_reg.edge_weight, next: hd_rd};
                hd_we = 1'b1; hd_wd = '{vld: 1'b1, idx: edge_cnt_reg[EIDX_W-1:0]};
            end
            S_DCLR: begin
                d_we = 1'b1; d_addr = sweep_reg[NODE_W-1:0];
                if (sweep_reg[NODE_W-1:0] == cmd_reg.source_node) d_wd = '0;
                if (sweep_reg[NODE_W] || (cmd_reg.action == ACT_CLEAR)) begin
                    hd_we = cmd_reg.action == ACT_CLEAR;
                    hd_addr = sweep_reg[NODE_W-1:0];
                    d_we = cmd_reg.action != ACT_CLEAR;
                end
                if (sweep_reg[NODE_W]) begin
                    d_we = 1'b0; hd_we = 1'b0;
                    h_we = cmd_reg.action != ACT_CLEAR;
                    h_wd = '{node: cmd_reg.source_node, cost: '0};
                end
            end
            S_POP_RD0: h_addr = '0;
            S_POP_RDL: h_addr = hsize_reg[HIDX_W-1:0];
            S_SIFT_RC: h_addr = lchild[HIDX_W-1:0];
            S_SIFT_RC2: h_addr = HIDX_W'(child_reg + 1'b1);
            S_SIFT_WR: begin
                h_we = 1'b1; h_addr = pos_reg[HIDX_W-1:0]; h_wd = last_reg;
            end
            S_SIFT_CMP: begin
                h_we = !sift_stop; h_addr = pos_reg[HIDX_W-1:0]; h_wd = sift_pick;
                d_addr = cur_reg.node;
            end
            S_POP_CHK: d_addr = cur_reg.node;
            S_HEAD_RD: hd_addr = cur_reg.node;
            S_EDGE_RD: e_addr = elink_reg.idx;
            S_EDGE_W: d_addr = e_rd.to;
            S_DIST_W: begin
                d_we = relax_ok; d_addr = edge_reg.to; d_wd = nd_sum;
            end
            S_PUSH_RP: h_addr = parent[HIDX_W-1:0];
            S_PUSH_CMP: begin
                h_we = 1'b1; h_addr = pos_reg[HIDX_W-1:0];
                if (pos_reg != '0 && h_rd.cost > nd_reg) h_wd = h_rd;
                else h_wd = '{node: edge_reg.to, cost: nd_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            sweep_reg <= '0;
            edge_cnt_reg <= '0;
            edge_lost_reg <= 1'b0;
            hsize_reg <= '0;
            res_valid <= 1'b0;
        end else begin
            if (res_valid && res_ready) res_valid <= 1'b0;
            case (state_reg)
                S_INIT: begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == (NODE_W+1)'(MAX_NODES - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (req_valid && req_ready) begin
                        cmd_reg <= req;
                        n_reg <= n_eff;
                        sweep_reg <= '0;
                        case (req.action)
                            ACT_CLEAR: begin
                                edge_cnt_reg <= '0;
                                edge_lost_reg <= 1'b0;
                                state_reg <= S_DCLR;
                            end
                            ACT_EDGE: begin
                                if (edge_cnt_reg >= CNT_W'(MAX_EDGES)) edge_lost_reg <= 1'b1;
                                else state_reg <= S_EHEAD_RD;
                            end
                            ACT_QUERY: begin
                                res.path_length <= '0;
                                res.found <= 1'b0;
                                res.overflow <= edge_lost_reg;
                                if (NCFG_W'(req.source_node) >= n_eff ||
                                    NCFG_W'(req.target_node) >= n_eff) begin
                                    res_valid <= 1'b1;
                                end else begin
                                    state_reg <= S_DCLR;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_EHEAD_RD: state_reg <= S_EHEAD_WR;
                S_EHEAD_WR: begin
                    edge_cnt_reg <= edge_cnt_reg + 1'b1;
                    state_reg <= S_IDLE;
                end
                S_DCLR: begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg[NODE_W]) begin
                        if (cmd_reg.action == ACT_CLEAR) state_reg <= S_IDLE;
                        else begin
                            hsize_reg <= CNT_W'(1);
                            state_reg <= S_POP_RD0;
                        end
                    end else if (sweep_reg == (NODE_W+1)'(MAX_NODES - 1)
                                 && cmd_reg.action == ACT_CLEAR) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_POP_RD0: begin
                    hsize_reg <= hsize_reg - 1'b1;
                    state_reg <= S_POP_RDL;
                end
                S_POP_RDL: begin
                    cur_reg <= h_rd;
                    pos_reg <= '0;
                    state_reg <= (hsize_reg == '0) ? S_POP_CHK : S_SIFT_RC;
                end
                S_SIFT_RC: begin
                    // first pass captures last; handled via pos==0 flag
                    if (pos_reg == '0) last_reg <= h_rd;
                    state_reg <= S_SIFT_RC2;
                    child_reg <= lchild;
                    if (lchild >= hsize_reg) state_reg <= S_SIFT_WR;
                end
                S_SIFT_RC2: begin
                    cchild_reg <= h_rd;
                    state_reg <= S_SIFT_CMP;
                end
                S_SIFT_CMP: begin
                    if (sift_stop) begin
                        state_reg <= S_SIFT_WR;
                    end else begin
                        pos_reg <= take_right ? child_reg + 1'b1 : child_reg;
                        state_reg <= S_SIFT_RC;
                    end
                end
                S_SIFT_WR: state_reg <= S_POP_CHK;
                S_POP_CHK: state_reg <= S_HEAD_RD;
                S_HEAD_RD: begin
                    if (cur_reg.cost > d_rd) begin
                        state_reg <= (hsize_reg == '0) ? S_DONE : S_POP_RD0;
                    end else if (cur_reg.node == cmd_reg.target_node) begin
                        res.path_length <= (cur_reg.cost > DIST_W'(LEN_MAX)) ?
                            LEN_MAX : cur_reg.cost[LEN_W-1:0];
                        res.found <= 1'b1;
                        res_valid <= 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_HEAD_W;
                    end
                end
                S_HEAD_W: begin
                    elink_reg <= hd_rd;
                    state_reg <= S_EDGE_RD;
                end
                S_EDGE_RD: begin
                    if (!elink_reg.vld) begin
                        state_reg <= (hsize_reg == '0) ? S_DONE : S_POP_RD0;
                    end else begin
                        state_reg <= S_EDGE_W;
                    end
                end
                S_EDGE_W: begin
                    edge_reg <= e_rd;
                    elink_reg <= e_rd.next;
                    state_reg <= S_DIST_W;
                end
                S_DIST_W: begin
                    nd_reg <= nd_sum;
                    if (relax_ok) begin
                        if (hsize_reg >= CNT_W'(HEAP_DEPTH)) begin
                            res.overflow <= 1'b1;
                            hsize_reg <= '0;
                            res_valid <= 1'b1;
                            state_reg <= S_IDLE;
                        end else begin
                            pos_reg <= hsize_reg;
                            hsize_reg <= hsize_reg + 1'b1;
                            state_reg <= S_PUSH_RP;
                        end
                    end else begin
                        state_reg <= S_EDGE_RD;
                    end
                end
                S_PUSH_RP: state_reg <= S_PUSH_CMP;
                S_PUSH_CMP: begin
                    if (pos_reg != '0 && h_rd.cost > nd_reg) begin
                        pos_reg <= parent;
                        state_reg <= S_PUSH_RP;
                    end else begin
                        state_reg <= S_EDGE_RD;
                    end
                end
                S_DONE: begin
                    res_valid <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shortest path core: graph loads and queries are
// sent over the request channel, a behavioural Dijkstra predicts each reply
// unless a directed row gives a fixed one, and replies are compared field by field as they arrive.
// ----------------------------------------------------------------------------
module tb_top;
    import spsp_pkg::*;

    localparam int  WATCHDOG_LIMIT = 1000000;
    localparam int  LONG_HOLD      = 3000;
    localparam int  DRAIN_CYCLES   = 1200;
    localparam logic [1:0] ACT_NOP = 2'd3;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_we = 1'b0;
    logic [NCFG_W-1:0] cfg_wdata = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    spsp_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    spsp_out_t m_data;

    always #6 aclk = ~aclk;

    single_pair_shortest_path_core uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // ---------------- graph mirror and Dijkstra ----------------
    logic [NODE_W-1:0] g_to [MAX_EDGES];
    logic [WGT_W-1:0]  g_wgt [MAX_EDGES];
    int                g_next [MAX_EDGES];
    int                g_head [MAX_NODES];
    int                g_edges;
    bit                g_lost;
    logic [NCFG_W-1:0] g_nodes;
    logic [DIST_W-1:0] best [MAX_NODES];
    logic [NODE_W-1:0] hp_node [HEAP_DEPTH];
    logic [DIST_W-1:0] hp_dist [HEAP_DEPTH];
    int                hp_size;

    spsp_out_t reply_q[$];
    int        req_count = 0;
    int        fail_count = 0;

    function automatic void graph_clear();
        for (int i = 0; i < MAX_NODES; i++) g_head[i] = -1;
        g_edges = 0;
        g_lost  = 0;
    endfunction

    function automatic bit heap_insert(logic [NODE_W-1:0] nd, logic [DIST_W-1:0] d);
        int i;
        int p;
        if (hp_size >= HEAP_DEPTH) return 0;
        i = hp_size;
        hp_size++;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (hp_dist[p] <= d) break;
            hp_node[i] = hp_node[p];
            hp_dist[i] = hp_dist[p];
            i = p;
        end
        hp_node[i] = nd;
        hp_dist[i] = d;
        return 1;
    endfunction

    function automatic void heap_take(output logic [NODE_W-1:0] nd,
                                      output logic [DIST_W-1:0] d);
        int i;
        int c;
        logic [NODE_W-1:0] ln;
        logic [DIST_W-1:0] ld;
        i  = 0;
        nd = hp_node[0];
        d  = hp_dist[0];
        hp_size--;
        if (hp_size == 0) return;
        ln = hp_node[hp_size];
        ld = hp_dist[hp_size];
        forever begin
            c = 2 * i + 1;
            if (c >= hp_size) break;
            if (c + 1 < hp_size && hp_dist[c+1] < hp_dist[c]) c++;
            if (hp_dist[c] >= ld) break;
            hp_node[i] = hp_node[c];
            hp_dist[i] = hp_dist[c];
            i = c;
        end
        hp_node[i] = ln;
        hp_dist[i] = ld;
    endfunction

    function automatic spsp_out_t shortest_path(logic [NODE_W-1:0] src,
                                                logic [NODE_W-1:0] dst);
        spsp_out_t r;
        int n;
        int e;
        logic [NODE_W-1:0] cn;
        logic [DIST_W-1:0] cd;
        logic [DIST_W-1:0] nd;
        r = '0;
        r.overflow = g_lost;
        n = (g_nodes < MAX_NODES) ? g_nodes : MAX_NODES;
        if (src >= n || dst >= n) return r;
        for (int i = 0; i < MAX_NODES; i++) best[i] = UNREACHABLE;
        hp_size = 0;
        best[src] = '0;
        void'(heap_insert(src, '0));
        while (hp_size > 0) begin
            heap_take(cn, cd);
            if (cd > best[cn]) continue;
            if (cn == dst) begin
                r.path_length = (cd > DIST_W'(LEN_MAX)) ? LEN_MAX : cd[LEN_W-1:0];
                r.found = 1'b1;
                return r;
            end
            e = g_head[cn];
            while (e >= 0 && e < MAX_EDGES) begin
                nd = cd + DIST_W'(g_wgt[e]);
                if (g_to[e] < n && nd < best[g_to[e]]) begin
                    best[g_to[e]] = nd;
                    if (!heap_insert(g_to[e], nd)) begin
                        r.overflow = 1'b1;
                        hp_size = 0;
                        return r;
                    end
                end
                e = g_next[e];
            end
        end
        return r;
    endfunction

    // ---------------- monitors ----------------
    bit        fixed_valid = 0;
    spsp_out_t fixed_reply;
    int        resp_count = 0;

    always @(posedge aclk) begin
        spsp_out_t exp;
        if (aresetn && s_valid && s_ready) begin
            req_count++;
            case (s_data.action)
                ACT_CLEAR: graph_clear();
                ACT_EDGE: begin
                    if (g_edges >= MAX_EDGES) g_lost = 1;
                    else begin
                        g_to[g_edges]   = s_data.edge_to;
                        g_wgt[g_edges]  = s_data.edge_weight;
                        g_next[g_edges] = g_head[s_data.edge_from];
                        g_head[s_data.edge_from] = g_edges;
                        g_edges++;
                    end
                end
                ACT_QUERY: begin
                    exp = shortest_path(s_data.source_node, s_data.target_node);
                    reply_q = {reply_q, (fixed_valid ? fixed_reply : exp)};
                end
                default: ;
            endcase
        end
        if (aresetn && m_valid && m_ready) begin
            resp_count++;
            if (reply_q.size() == 0) begin
                $error("unexpected reply %h", m_data);
                fail_count++;
            end else begin
                exp = reply_q.pop_front();
                if (m_data.path_length !== exp.path_length) begin
                    $error("path_length: expected %0d, got %0d",
                           exp.path_length, m_data.path_length);
                    fail_count++;
                end
                if (m_data.found !== exp.found) begin
                    $error("found: expected %0b, got %0b", exp.found, m_data.found);
                    fail_count++;
                end
                if (m_data.overflow !== exp.overflow) begin
                    $error("overflow: expected %0b, got %0b",
                           exp.overflow, m_data.overflow);
                    fail_count++;
                end
            end
        end
    end

    // no progress on either channel for too long
    int stuck = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stuck = 0;
        else stuck++;
        if (stuck >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------- reply side ----------------
    bit gaps_on = 1;
    int hold_req = 0;
    int hold_done = 0;

    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req != hold_done) begin
                m_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_done = hold_req;
                m_ready = 1'b1;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge aclk);
                m_ready = 1'b1;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // ---------------- request side ----------------
    typedef struct {
        spsp_in_t  req;
        bit        fixed;
        spsp_out_t reply;
    } stim_row_t;

    // entered and left at a falling edge
    task automatic send_req(spsp_in_t req, bit fixed = 0, spsp_out_t reply = '0);
        int n0;
        n0 = req_count;
        s_data      = req;
        fixed_valid = fixed;
        fixed_reply = reply;
        s_valid     = 1'b1;
        do @(negedge aclk); while (req_count == n0);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (reply_q.size() != 0) @(negedge aclk);
    endtask

    task automatic set_nodes(logic [NCFG_W-1:0] v);
        wait_drained();
        // a clear or edge load may still be in flight
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we  = 1'b0;
        g_nodes = v;
    endtask

    function automatic logic [NODE_W-1:0] pick_node(int span);
        if ($urandom_range(0, 9) == 0) return NODE_W'($urandom);
        return NODE_W'($urandom_range(0, span - 1));
    endfunction

    function automatic spsp_in_t rand_req(int span);
        spsp_in_t r;
        int sel;
        r = '0;
        r.edge_from   = pick_node(span);
        r.edge_to     = pick_node(span);
        r.source_node = pick_node(span);
        r.target_node = pick_node(span);
        r.edge_weight = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 50);
        sel = $urandom_range(0, 99);
        if (sel < 55)      r.action = ACT_EDGE;
        else if (sel < 90) r.action = ACT_QUERY;
        else if (sel < 95) r.action = ACT_CLEAR;
        else               r.action = ACT_NOP;
        return r;
    endfunction

    function automatic spsp_in_t mk(logic [1:0] a, int f, int t, logic [31:0] w,
                                    int s, int d);
        spsp_in_t r;
        r.action = a; r.edge_from = NODE_W'(f); r.edge_to = NODE_W'(t);
        r.edge_weight = w;
        r.source_node = NODE_W'(s); r.target_node = NODE_W'(d);
        return r;
    endfunction

    function automatic spsp_out_t rep(logic [47:0] len, bit fnd, bit ovf);
        spsp_out_t r;
        r.path_length = len; r.found = fnd; r.overflow = ovf;
        return r;
    endfunction

    stim_row_t directed[$];
    logic [NCFG_W-1:0] node_settings[6] = '{11'd1024, 11'd2047, 11'd0, 11'd1,
                                           11'd7, 11'd1024};

    initial begin
        graph_clear();
        g_nodes = 11'd1024;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        directed = '{
            '{mk(ACT_QUERY, 0, 0, 0, 0, 0),          1, rep(0, 1, 0)},
            '{mk(ACT_QUERY, 0, 0, 0, 1023, 5),       1, rep(0, 0, 0)},
            '{mk(ACT_EDGE, 0, 1, 32'hFFFF_FFFF, 0, 0),    0, rep(0, 0, 0)},
            '{mk(ACT_EDGE, 1, 1023, 32'hFFFF_FFFF, 0, 0), 0, rep(0, 0, 0)},
            '{mk(ACT_EDGE, 1023, 2, 0, 0, 0),        0, rep(0, 0, 0)},
            '{mk(ACT_EDGE, 0, 2, 32'h1_0000, 0, 0),  0, rep(0, 0, 0)},
            '{mk(ACT_QUERY, 0, 0, 0, 0, 1023),       1, rep(48'h1_FFFF_FFFE, 1, 0)},
            '{mk(ACT_QUERY, 0, 0, 0, 0, 2),          0, rep(0, 0, 0)},
            '{mk(ACT_NOP, 1023, 1023, 32'hFFFF_FFFF, 1023, 1023), 0, rep(0, 0, 0)},
            '{mk(ACT_QUERY, 0, 0, 0, 2, 0),          1, rep(0, 0, 0)},
            '{mk(ACT_EDGE, 10'h2AA, 10'h155, 32'hAAAA_5555, 0, 0), 0, rep(0, 0, 0)},
            '{mk(ACT_EDGE, 10'h155, 10'h2AA, 32'h5555_AAAA, 0, 0), 0, rep(0, 0, 0)},
            '{mk(ACT_QUERY, 0, 0, 0, 10'h2AA, 10'h155), 1, rep(48'hAAAA_5555, 1, 0)},
            '{mk(ACT_QUERY, 0, 0, 0, 10'h155, 10'h155), 1, rep(0, 1, 0)},
            '{mk(ACT_CLEAR, 0, 0, 0, 0, 0),          0, rep(0, 0, 0)},
            '{mk(ACT_QUERY, 0, 0, 0, 0, 1),          1, rep(0, 0, 0)},
            '{mk(ACT_EDGE, 3, 4, 5, 0, 0),           0, rep(0, 0, 0)},
            '{mk(ACT_EDGE, 4, 3, 1, 0, 0),           0, rep(0, 0, 0)},
            '{mk(ACT_QUERY, 0, 0, 0, 3, 4),          0, rep(0, 0, 0)},
            '{mk(ACT_QUERY, 0, 0, 0, 4, 3),          0, rep(0, 0, 0)}
        };

        @(negedge aclk);
        foreach (directed[i]) send_req(directed[i].req, directed[i].fixed, directed[i].reply);
        fixed_valid = 0;

        foreach (node_settings[p]) begin
            set_nodes(node_settings[p]);
            if (p == 5) gaps_on = 0;
            for (int k = 0; k < 14; k++) begin
                if (p == 1 && k == 3) hold_req++;     // stall replies, keep requesting
                if (p == 2 && k == 8) wait_drained(); // quiet sender until all back
                send_req(rand_req((p == 0 || p == 5) ? 12 : 8));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/spsp_pkg.sv
src/spsp_ram.sv
src/spsp_engine.sv
src/single_pair_shortest_path_core.sv
tb/tb_top.sv
